>>> rtl/core/btp_pkg.sv
package btp_pkg;

    localparam int ADDRESS_BITS       = 32;
    localparam int PORT_BITS          = 8;
    localparam int PLEN_W             = 6;
    localparam int DEPTH_W            = $clog2(ADDRESS_BITS + 1);
    localparam int NODE_COUNT_DEFAULT = 4096;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CONFLICT = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic                    operation;
        logic [ADDRESS_BITS-1:0] address;
        logic [PLEN_W-1:0]       prefix_length;
        logic [PORT_BITS-1:0]    port_in;
    } btp_req_t;

    typedef struct packed {
        logic                 found;
        logic [PORT_BITS-1:0] port_out;
        logic [1:0]           status;
    } btp_rsp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } btp_state_t;

endpackage

>>> rtl/core/btp_node_mem.sv
module btp_node_mem #(
    parameter int NODE_COUNT = btp_pkg::NODE_COUNT_DEFAULT,
    parameter int IDX_W      = $clog2(NODE_COUNT),
    parameter int ENTRY_W    = 2 * IDX_W + 1 + btp_pkg::PORT_BITS
) (
    input  logic               clk,
    input  logic               rd_en,
    input  logic [IDX_W-1:0]   rd_addr,
    output logic [ENTRY_W-1:0] rd_data,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_addr,
    input  logic [ENTRY_W-1:0] wr_data
);

    // entry layout: {left child, right child, route valid, route port}
    logic [ENTRY_W-1:0] mem [NODE_COUNT];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/core/btp_walker.sv
module btp_walker #(
    parameter int NODE_COUNT = btp_pkg::NODE_COUNT_DEFAULT,
    parameter int IDX_W      = $clog2(NODE_COUNT),
    parameter int ENTRY_W    = 2 * IDX_W + 1 + btp_pkg::PORT_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  btp_pkg::btp_req_t  req,
    output logic               res_valid,
    input  logic               res_take,
    output btp_pkg::btp_rsp_t  res,
    output logic               mem_rd_en,
    output logic [IDX_W-1:0]   mem_rd_addr,
    input  logic [ENTRY_W-1:0] mem_rd_data,
    output logic               mem_wr_en,
    output logic [IDX_W-1:0]   mem_wr_addr,
    output logic [ENTRY_W-1:0] mem_wr_data
);

    localparam int USED_W = $clog2(NODE_COUNT + 1);
    localparam int AB     = btp_pkg::ADDRESS_BITS;
    localparam int PB     = btp_pkg::PORT_BITS;
    localparam int DW     = btp_pkg::DEPTH_W;
    localparam int LW     = btp_pkg::PLEN_W;

    btp_pkg::btp_state_t state_reg, state_next;

    logic              op_reg, op_next;
    logic [AB-1:0]     addr_reg, addr_next;
    logic [DW-1:0]     len_reg, len_next;
    logic [PB-1:0]     port_reg, port_next;
    logic [DW-1:0]     depth_reg, depth_next;
    logic [IDX_W-1:0]  node_reg, node_next;
    logic              fresh_reg, fresh_next;
    logic              hit_reg, hit_next;
    logic [PB-1:0]     hit_port_reg, hit_port_next;
    logic [1:0]        status_reg, status_next;
    logic [IDX_W-1:0]  root_left_reg, root_left_next;
    logic [IDX_W-1:0]  root_right_reg, root_right_next;
    logic [USED_W-1:0] used_reg, used_next;

    logic              node_is_root;
    logic [IDX_W-1:0]  cur_left, cur_right, child, new_node;
    logic              cur_valid, dir, store_full;
    logic [PB-1:0]     cur_port;
    logic              look_hit;
    logic [PB-1:0]     look_port;
    logic [DW-1:0]     plen_clamped;

    assign node_is_root = (node_reg == '0);
    assign new_node     = used_reg[IDX_W-1:0];
    assign store_full   = (used_reg == USED_W'(NODE_COUNT));
    assign dir          = addr_reg[AB-1];

    // root lives in registers so it reads as empty straight after reset;
    // a freshly allocated node is known to be all zero and is not read
    always_comb
    begin
        if (node_is_root)
        begin
            cur_left  = root_left_reg;
            cur_right = root_right_reg;
            cur_valid = 1'b0;
            cur_port  = '0;
        end
        else if (fresh_reg)
        begin
            cur_left  = '0;
            cur_right = '0;
            cur_valid = 1'b0;
            cur_port  = '0;
        end
        else
        begin
            cur_left  = mem_rd_data[ENTRY_W-1 -: IDX_W];
            cur_right = mem_rd_data[ENTRY_W-IDX_W-1 -: IDX_W];
            cur_valid = mem_rd_data[PB];
            cur_port  = mem_rd_data[PB-1:0];
        end
    end

    assign child     = dir ? cur_right : cur_left;
    assign look_hit  = hit_reg | cur_valid;
    assign look_port = cur_valid ? cur_port : hit_port_reg;

    always_comb
    begin
        if (req.prefix_length == '0)
        begin
            plen_clamped = DW'(1);
        end
        else if (req.prefix_length > LW'(AB))
        begin
            plen_clamped = DW'(AB);
        end
        else
        begin
            plen_clamped = DW'(req.prefix_length);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= btp_pkg::S_IDLE;
            root_left_reg  <= '0;
            root_right_reg <= '0;
            used_reg       <= USED_W'(1);
        end
        else
        begin
            state_reg      <= state_next;
            root_left_reg  <= root_left_next;
            root_right_reg <= root_right_next;
            used_reg       <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        addr_reg     <= addr_next;
        len_reg      <= len_next;
        port_reg     <= port_next;
        depth_reg    <= depth_next;
        node_reg     <= node_next;
        fresh_reg    <= fresh_next;
        hit_reg      <= hit_next;
        hit_port_reg <= hit_port_next;
        status_reg   <= status_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        addr_next       = addr_reg;
        len_next        = len_reg;
        port_next       = port_reg;
        depth_next      = depth_reg;
        node_next       = node_reg;
        fresh_next      = fresh_reg;
        hit_next        = hit_reg;
        hit_port_next   = hit_port_reg;
        status_next     = status_reg;
        root_left_next  = root_left_reg;
        root_right_next = root_right_reg;
        used_next       = used_reg;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = child;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = node_reg;
        mem_wr_data     = '0;
        req_stall       = 1'b1;
        res_valid       = 1'b0;

        case (state_reg)
            btp_pkg::S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    op_next       = req.operation;
                    addr_next     = req.address;
                    len_next      = plen_clamped;
                    port_next     = req.port_in;
                    depth_next    = '0;
                    node_next     = '0;
                    fresh_next    = 1'b0;
                    hit_next      = 1'b0;
                    hit_port_next = '0;
                    status_next   = btp_pkg::ST_OK;
                    state_next    = btp_pkg::S_WALK;
                end
            end

            btp_pkg::S_WALK:
            begin
                if (!op_reg)
                begin
                    hit_next      = look_hit;
                    hit_port_next = look_port;
                    if (depth_reg == DW'(AB) || child == '0)
                    begin
                        status_next = btp_pkg::ST_OK;
                        state_next  = btp_pkg::S_DONE;
                    end
                    else
                    begin
                        mem_rd_en  = 1'b1;
                        node_next  = child;
                        depth_next = depth_reg + DW'(1);
                        addr_next  = addr_reg << 1;
                    end
                end
                else if (depth_reg == len_reg)
                begin
                    // target node is never the root here
                    if (!cur_valid)
                    begin
                        mem_wr_en   = 1'b1;
                        mem_wr_data = {cur_left, cur_right, 1'b1, port_reg};
                        status_next = btp_pkg::ST_OK;
                    end
                    else if (cur_port != port_reg)
                    begin
                        status_next = btp_pkg::ST_CONFLICT;
                    end
                    else
                    begin
                        status_next = btp_pkg::ST_OK;
                    end
                    state_next = btp_pkg::S_DONE;
                end
                else if (child != '0)
                begin
                    mem_rd_en  = 1'b1;
                    node_next  = child;
                    depth_next = depth_reg + DW'(1);
                    addr_next  = addr_reg << 1;
                end
                else if (store_full)
                begin
                    // a fresh node stays in the trie, so clear it now
                    mem_wr_en   = fresh_reg;
                    mem_wr_data = '0;
                    status_next = btp_pkg::ST_FULL;
                    state_next  = btp_pkg::S_DONE;
                end
                else
                begin
                    used_next = used_reg + USED_W'(1);
                    if (node_is_root)
                    begin
                        if (dir)
                        begin
                            root_right_next = new_node;
                        end
                        else
                        begin
                            root_left_next = new_node;
                        end
                    end
                    else
                    begin
                        mem_wr_en   = 1'b1;
                        mem_wr_data = {dir ? cur_left : new_node,
                                       dir ? new_node : cur_right,
                                       cur_valid, cur_port};
                    end
                    node_next  = new_node;
                    fresh_next = 1'b1;
                    depth_next = depth_reg + DW'(1);
                    addr_next  = addr_reg << 1;
                end
            end

            btp_pkg::S_DONE:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = btp_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = btp_pkg::S_IDLE;
            end
        endcase
    end

    assign res.found    = op_reg ? 1'b0 : hit_reg;
    assign res.port_out = (op_reg || !hit_reg) ? '0 : hit_port_reg;
    assign res.status   = op_reg ? status_reg : btp_pkg::ST_OK;

endmodule

>>> rtl/core/binary_trie_prefix_lookup_unit.sv
// Longest-prefix route lookup over a binary trie held in one node memory.
// Request channel (req_valid / req_stall / req): operation 0 looks up an
// address, operation 1 inserts a route prefix (address, prefix_length, port_in).
// Response channel (rsp_valid / rsp_stall / rsp): one response per request,
// in order, carrying found, port_out and status (ok, conflict, store full).
// One request is handled at a time. The walk descends one trie level per
// cycle through the node memory port. The next request is taken the cycle
// after the response is handed to the output register.
// Reset empties the trie (root only, no routes) and needs no clearing pass;
// the node store is only read at entries that an insert has written.
// While rsp_stall is high the response is held; one further response can be
// finished internally, after which req_stall stays high until space frees.
module binary_trie_prefix_lookup_unit #(
    parameter int NODE_COUNT = btp_pkg::NODE_COUNT_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  btp_pkg::btp_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output btp_pkg::btp_rsp_t rsp
);

    localparam int IDX_W   = $clog2(NODE_COUNT);
    localparam int ENTRY_W = 2 * IDX_W + 1 + btp_pkg::PORT_BITS;

    logic               mem_rd_en, mem_wr_en;
    logic [IDX_W-1:0]   mem_rd_addr, mem_wr_addr;
    logic [ENTRY_W-1:0] mem_rd_data, mem_wr_data;

    logic              res_valid, res_take, slot_free;
    btp_pkg::btp_rsp_t res;

    logic              rsp_valid_reg, rsp_valid_next;
    btp_pkg::btp_rsp_t rsp_reg, rsp_next;

    btp_node_mem #(
        .NODE_COUNT (NODE_COUNT),
        .IDX_W      (IDX_W),
        .ENTRY_W    (ENTRY_W)
    ) u_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    btp_walker #(
        .NODE_COUNT (NODE_COUNT),
        .IDX_W      (IDX_W),
        .ENTRY_W    (ENTRY_W)
    ) u_walker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .res_valid   (res_valid),
        .res_take    (res_take),
        .res         (res),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data)
    );

    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign res_take  = res_valid && slot_free;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (res_take)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = res;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> tb/tb_binary_trie_prefix_lookup_unit.sv
`timescale 1ns / 100ps

module tb_binary_trie_prefix_lookup_unit;

    localparam int NODE_COUNT     = btp_pkg::NODE_COUNT_DEFAULT;
    localparam int NODE_W         = $clog2(NODE_COUNT);
    localparam int POOL_SIZE      = 12;
    localparam int PHASE_ITEMS    = 280;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int REPORT_LIMIT   = 10;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    logic              clk;
    logic              rst_n;
    logic              req_valid;
    logic              req_stall;
    btp_pkg::btp_req_t req;
    logic              rsp_valid;
    logic              rsp_stall;
    btp_pkg::btp_rsp_t rsp;

    // shadow trie
    logic [NODE_W-1:0]             node_zero      [NODE_COUNT];
    logic [NODE_W-1:0]             node_one       [NODE_COUNT];
    logic                          node_has_route [NODE_COUNT];
    logic [btp_pkg::PORT_BITS-1:0] node_port      [NODE_COUNT];
    int unsigned                   alloc_count;

    btp_pkg::btp_rsp_t pending_rsp[$];
    btp_pkg::btp_rsp_t front_rsp;
    logic [31:0]       route_pool [POOL_SIZE];

    int req_idle_pct;
    int rsp_stall_pct;
    int quiet_cycles;
    int fail_count;
    int rsp_count;
    int lookup_count;
    int hit_count;
    int insert_count;
    int conflict_count;
    int full_count;

    binary_trie_prefix_lookup_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic btp_pkg::btp_rsp_t trie_predict(input btp_pkg::btp_req_t item);
        btp_pkg::btp_rsp_t res;
        int unsigned       len;
        int unsigned       lvl;
        logic [NODE_W-1:0] cur;
        logic [NODE_W-1:0] nxt;
        logic              dir;
        logic              stopped;
        res     = '0;
        cur     = '0;
        stopped = 1'b0;
        if (item.operation == OP_INSERT)
        begin
            len = 32'(item.prefix_length);
            if (len < 1)
                len = 1;
            if (len > btp_pkg::ADDRESS_BITS)
                len = btp_pkg::ADDRESS_BITS;
            for (lvl = 1; lvl <= len && !stopped; lvl++)
            begin
                dir = item.address[btp_pkg::ADDRESS_BITS - lvl];
                nxt = dir ? node_one[cur] : node_zero[cur];
                if (nxt == '0)
                begin
                    if (alloc_count >= NODE_COUNT)
                    begin
                        res.status = btp_pkg::ST_FULL;
                        stopped    = 1'b1;
                    end
                    else
                    begin
                        nxt = alloc_count[NODE_W-1:0];
                        alloc_count++;
                        node_zero[nxt]      = '0;
                        node_one[nxt]       = '0;
                        node_has_route[nxt] = 1'b0;
                        node_port[nxt]      = '0;
                        if (dir)
                            node_one[cur] = nxt;
                        else
                            node_zero[cur] = nxt;
                    end
                end
                if (!stopped)
                    cur = nxt;
            end
            if (!stopped)
            begin
                if (!node_has_route[cur])
                begin
                    node_has_route[cur] = 1'b1;
                    node_port[cur]      = item.port_in;
                    res.status          = btp_pkg::ST_OK;
                end
                else if (node_port[cur] != item.port_in)
                    res.status = btp_pkg::ST_CONFLICT;
                else
                    res.status = btp_pkg::ST_OK;
            end
        end
        else
        begin
            for (lvl = 1; lvl <= btp_pkg::ADDRESS_BITS && !stopped; lvl++)
            begin
                dir = item.address[btp_pkg::ADDRESS_BITS - lvl];
                nxt = dir ? node_one[cur] : node_zero[cur];
                if (nxt == '0)
                    stopped = 1'b1;
                else
                begin
                    cur = nxt;
                    if (node_has_route[cur])
                    begin
                        res.found    = 1'b1;
                        res.port_out = node_port[cur];
                    end
                end
            end
        end
        return res;
    endfunction

    task automatic report_failure(input string what, input btp_pkg::btp_rsp_t want,
                                  input btp_pkg::btp_rsp_t got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%0t: %s: expected found=%0b port=%0d status=%0d, %s%0b port=%0d status=%0d",
                     $realtime, what, want.found, want.port_out, want.status,
                     "got found=", got.found, got.port_out, got.status);
    endtask

    // response checker and receiver stall generator
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0)
        begin
            rsp_count++;
            if (pending_rsp.size() == 0)
                report_failure("response with nothing outstanding", '0, rsp);
            else
            begin
                front_rsp = pending_rsp.pop_front();
                if (rsp.found !== front_rsp.found || rsp.port_out !== front_rsp.port_out ||
                    rsp.status !== front_rsp.status)
                    report_failure("response mismatch", front_rsp, rsp);
            end
        end
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("watchdog: nothing moved for %0d cycles, %0d responses outstanding",
                     WATCHDOG_LIMIT, pending_rsp.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // valid is only dropped when the next request idles, so it never toggles within a step
    task automatic send_request(input btp_pkg::btp_req_t item);
        btp_pkg::btp_rsp_t want;
        if (req_idle_pct != 0)
        begin
            while ($urandom_range(99) < req_idle_pct)
            begin
                req_valid <= 1'b0;
                @(posedge clk);
            end
        end
        want = trie_predict(item);
        pending_rsp.push_back(want);
        if (item.operation == OP_INSERT)
        begin
            insert_count++;
            if (want.status == btp_pkg::ST_CONFLICT)
                conflict_count++;
            if (want.status == btp_pkg::ST_FULL)
                full_count++;
        end
        else
        begin
            lookup_count++;
            if (want.found)
                hit_count++;
        end
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall !== 1'b0)
            @(posedge clk);
    endtask

    task automatic send_lookup(input logic [31:0] addr);
        btp_pkg::btp_req_t item;
        item               = '0;
        item.operation     = OP_LOOKUP;
        item.address       = addr;
        item.prefix_length = btp_pkg::PLEN_W'($urandom_range(63));
        item.port_in       = btp_pkg::PORT_BITS'($urandom_range(255));
        send_request(item);
    endtask

    task automatic send_insert(input logic [31:0] addr, input int unsigned plen,
                               input int unsigned port);
        btp_pkg::btp_req_t item;
        item               = '0;
        item.operation     = OP_INSERT;
        item.address       = addr;
        item.prefix_length = plen[btp_pkg::PLEN_W-1:0];
        item.port_in       = port[btp_pkg::PORT_BITS-1:0];
        send_request(item);
    endtask

    task automatic test_empty_trie();
        send_lookup(32'h0000_0000);
        send_lookup(32'hFFFF_FFFF);
    endtask

    task automatic test_longest_match();
        send_insert(32'h0A00_0000, 8, 10);
        send_insert(32'h0A01_0200, 24, 255);
        send_lookup(32'h0A01_0203);
        send_lookup(32'h0A7F_0000);
        send_lookup(32'h0B00_0000);
    endtask

    task automatic test_repeat_and_conflict();
        send_insert(32'h0A00_0000, 8, 10);
        send_insert(32'h0A00_0000, 8, 20);
        send_lookup(32'h0A7F_0000);
    endtask

    // a /16 landing on the interior node that a /24 created
    task automatic test_unvalued_node();
        send_insert(32'hC0A8_0100, 24, 1);
        send_insert(32'hC0A8_0000, 16, 2);
        send_lookup(32'hC0A8_FF00);
        send_lookup(32'hC0A8_0101);
    endtask

    task automatic test_length_limits();
        send_insert(32'hFFFF_FFFF, 0, 0);
        send_lookup(32'h8000_0000);
        send_insert(32'hFFFF_FFFF, 63, 8'hAA);
        send_insert(32'h0000_0000, 32, 8'h55);
        send_lookup(32'hFFFF_FFFF);
        send_lookup(32'h0000_0000);
        send_insert(32'h1234_5678, 33, 8'h81);
        send_lookup(32'h1234_5678);
    endtask

    // addresses cluster around a few bases so routes overlap and lookups walk deep
    task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
        logic [31:0] addr;
        logic [31:0] mask;
        int          flip;
        int          sel;
        int unsigned plen;
        int unsigned port;
        req_idle_pct  = idle_pct;
        rsp_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
        begin
            flip = $urandom_range(32);
            mask = (flip == 0) ? 32'h0 : (32'hFFFF_FFFF >> (32 - flip));
            addr = route_pool[$urandom_range(POOL_SIZE - 1)] ^ ($urandom() & mask);
            sel  = $urandom_range(99);
            if (sel < 5)
                addr = $urandom();
            if (sel < 40)
            begin
                if ($urandom_range(99) < 6)
                    plen = $urandom_range(63);
                else
                    plen = $urandom_range(32, 1);
                if ($urandom_range(3) == 0)
                    port = ($urandom_range(1) == 0) ? 0 : 255;
                else
                    port = $urandom_range(255);
                send_insert(addr, plen, port);
            end
            else
                send_lookup(addr);
        end
    endtask

    task automatic test_store_full();
        int guard;
        req_idle_pct  = 0;
        rsp_stall_pct = 0;
        guard         = 0;
        while (alloc_count < NODE_COUNT && guard < 400)
        begin
            send_insert($urandom(), 32, $urandom_range(255));
            guard++;
        end
        send_insert($urandom(), 32, $urandom_range(255));
        send_insert(route_pool[0], 1, $urandom_range(255));
        send_lookup(route_pool[1]);
        send_lookup($urandom());
    endtask

    initial
    begin
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req            = '0;
        req_idle_pct   = 0;
        rsp_stall_pct  = 0;
        lookup_count   = 0;
        hit_count      = 0;
        insert_count   = 0;
        conflict_count = 0;
        full_count     = 0;
        node_zero[0]      = '0;
        node_one[0]       = '0;
        node_has_route[0] = 1'b0;
        node_port[0]      = '0;
        alloc_count       = 1;
        route_pool[0] = 32'h0000_0000;
        route_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            route_pool[i] = $urandom();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_trie();
        test_longest_match();
        test_repeat_and_conflict();
        test_unvalued_node();
        test_length_limits();
        test_random_traffic(0, 0, PHASE_ITEMS);
        test_random_traffic(67, 0, PHASE_ITEMS);
        test_random_traffic(0, 67, PHASE_ITEMS);
        test_random_traffic(37, 37, PHASE_ITEMS);
        test_store_full();
        test_random_traffic(37, 37, 100);

        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending_rsp.size() != 0)
            $display("%0d responses never arrived", pending_rsp.size());
        $display("Covered %0d lookups (%0d hits), %0d inserts (%0d conflicts, %0d store full)",
                 lookup_count, hit_count, insert_count, conflict_count, full_count);
        $display("under four idle/stall mixes; %0d of %0d nodes used, %0d responses checked",
                 alloc_count, NODE_COUNT, rsp_count);
        if (fail_count == 0 && pending_rsp.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> binary_trie_prefix_lookup_unit.f
rtl/core/btp_pkg.sv
rtl/core/btp_node_mem.sv
rtl/core/btp_walker.sv
rtl/core/binary_trie_prefix_lookup_unit.sv
tb/tb_binary_trie_prefix_lookup_unit.sv
